/* hw/rtl/ja15_pkg.sv */
package ja15_pkg;

  // marker byte values
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_APP15  = 8'hEF;

  // depth of the queue between parser and output stage
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // final status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  // one result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } res_t;

  // queue head towards the output stage
  typedef struct packed {
    logic valid;
    res_t res;
  } head_t;

endpackage

/* hw/rtl/jpeg_app15_segment_extract_core.sv */
// a result is written into a queue entry and then into the output register
// one byte per cycle while in_stall_o is low; each byte is parsed combinationally
// a four-entry queue and an output register let the two sides stall independently
// reset: asynchronous, active low; walk rearms at the first header byte, length reads 0
// writing the length register also restarts the walk at the first byte
module jpeg_app15_segment_extract_core import ja15_pkg::*; #(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        image_length_we_i,
  input  logic [23:0] image_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  logic  accept;
  logic  q_push, q_pop, q_full;
  res_t  front_res, out_res;
  head_t q_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // parser
  ja15_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .image_length_we_i (image_length_we_i),
    .image_length_i    (image_length_i),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .push_o            (q_push),
    .res_o             (front_res)
  );

  // decoupling queue
  ja15_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .res_i  (front_res),
    .pop_i  (q_pop),
    .head_o (q_head),
    .full_o (q_full)
  );

  // output stage
  ja15_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign byte_valid_o   = out_res.byte_valid;
  assign last_o         = out_res.last;
  assign status_o       = out_res.status;

  // queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue overflow");

  // a status-only item is always the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> last_o)
    else $error("status-only item without last");

  // status is ok on every non-final item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK))
    else $error("status set on non-final item");

  // data items always carry ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (status_o == ST_OK))
    else $error("error status on payload item");

endmodule

/* hw/rtl/ja15_front.sv */
module ja15_front import ja15_pkg::*; #(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        image_length_we_i,
  input  logic [23:0] image_length_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  output logic        push_o,
  output res_t        res_o
);

  localparam int unsigned CW = LEN_BITS + 2;

  typedef enum logic [8:0] {
    PH_HDR0    = 9'b000000001,
    PH_HDR1    = 9'b000000010,
    PH_SCAN    = 9'b000000100,
    PH_MARKER  = 9'b000001000,
    PH_LEN_HI  = 9'b000010000,
    PH_LEN_LO  = 9'b000100000,
    PH_SKIP    = 9'b001000000,
    PH_PAYLOAD = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_e;

  phase_e              phase_q, phase_d, phase_n;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [LEN_BITS-1:0] pos_q, pos_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [15:0]         rem_q, rem_d;
  logic                app15_q, app15_d;

  logic [LEN_BITS+23:0] len_wide;
  logic [CW-1:0]        pos_x, len_x, seg_x;
  logic [15:0]          seg, rem_dec;
  logic                 last_byte;
  logic                 is_standalone;

  // register width follows the length parameter
  assign len_wide = {{LEN_BITS{1'b0}}, image_length_i};
  assign len_d    = len_wide[LEN_BITS-1:0];

  assign pos_x     = {2'b00, pos_q};
  assign len_x     = {2'b00, len_q};
  assign seg       = {len_hi_q, data_byte_i};
  assign seg_x     = {{(CW-16){1'b0}}, seg};
  assign rem_dec   = (rem_q == 16'd0) ? 16'd0 : rem_q - 16'd1;
  assign last_byte = (pos_x + CW'(1)) >= len_x;

  assign is_standalone = (data_byte_i == MK_SOI) || (data_byte_i == MK_TEM) ||
                         ((data_byte_i >= MK_RST0) && (data_byte_i <= MK_RST7));

  // parse step for one item
  always_comb begin
    phase_n  = phase_q;
    len_hi_d = len_hi_q;
    rem_d    = rem_q;
    app15_d  = app15_q;
    push_o   = 1'b0;
    res_o    = '{payload_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, status: ST_OK};

    unique case (phase_q)
      PH_HDR0: begin
        if ((len_q <= LEN_BITS'(4)) || (data_byte_i != MK_PREFIX)) begin
          push_o       = 1'b1;
          res_o.status = ST_INVALID;
          phase_n      = PH_DONE;
        end else begin
          phase_n = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (data_byte_i != MK_SOI) begin
          push_o       = 1'b1;
          res_o.status = ST_INVALID;
          phase_n      = PH_DONE;
        end else begin
          phase_n = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if ((data_byte_i == MK_PREFIX) && !last_byte) phase_n = PH_MARKER;
      end
      PH_MARKER: begin
        if ((data_byte_i == MK_SOS) || (data_byte_i == MK_EOI)) begin
          push_o       = 1'b1;
          res_o.status = ST_MALFORMED;
          phase_n      = PH_DONE;
        end else if (is_standalone) begin
          phase_n = PH_SCAN;
        end else if ((pos_x + CW'(2)) >= len_x) begin
          push_o       = 1'b1;
          res_o.status = ST_MALFORMED;
          phase_n      = PH_DONE;
        end else begin
          app15_d = (data_byte_i == MK_APP15);
          phase_n = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_d = data_byte_i;
        phase_n  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if ((seg < 16'd2) || ((pos_x + seg_x) > (len_x + CW'(1)))) begin
          push_o       = 1'b1;
          res_o.status = ST_MALFORMED;
          phase_n      = PH_DONE;
        end else if (app15_q) begin
          if (seg == 16'd2) begin
            push_o  = 1'b1;
            phase_n = PH_DONE;
          end else begin
            rem_d   = seg - 16'd2;
            phase_n = PH_PAYLOAD;
          end
        end else if (seg == 16'd2) begin
          phase_n = PH_SCAN;
        end else begin
          rem_d   = seg - 16'd2;
          phase_n = PH_SKIP;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 16'd0) phase_n = PH_SCAN;
      end
      PH_PAYLOAD: begin
        rem_d              = rem_dec;
        push_o             = 1'b1;
        res_o.payload_byte = data_byte_i;
        res_o.byte_valid   = 1'b1;
        res_o.last         = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) phase_n = PH_DONE;
      end
      PH_DONE: begin
      end
      default: begin
        phase_n = PH_HDR0;
      end
    endcase

    // file ends without a final result
    if (!push_o && (phase_n != PH_DONE) && last_byte) begin
      push_o       = 1'b1;
      res_o.status = ST_MALFORMED;
      phase_n      = PH_DONE;
    end

    // rearm at the file boundary
    if (last_byte) begin
      pos_d   = '0;
      phase_d = PH_HDR0;
    end else begin
      pos_d   = pos_q + LEN_BITS'(1);
      phase_d = phase_n;
    end

    if (!accept_i) push_o = 1'b0;
  end

  // walk state, restarted by a length write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      len_q    <= '0;
      pos_q    <= '0;
      len_hi_q <= '0;
      rem_q    <= '0;
      app15_q  <= 1'b0;
    end else if (image_length_we_i) begin
      len_q   <= len_d;
      pos_q   <= '0;
      phase_q <= PH_HDR0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_hi_q <= len_hi_d;
      rem_q    <= rem_d;
      app15_q  <= app15_d;
    end
  end

endmodule

/* hw/rtl/ja15_queue.sv */
module ja15_queue import ja15_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  res_t  res_i,
  input  logic  pop_i,
  output head_t head_o,
  output logic  full_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.res   = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= res_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

/* hw/rtl/ja15_back.sv */
module ja15_back import ja15_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  head_t head_i,
  output logic  pop_o,
  input  logic  out_stall_i,
  output logic  out_valid_o,
  output res_t  out_o
);

  logic out_valid_q;
  res_t out_q;

  // load the register when empty or when its item is taken
  assign pop_o       = head_i.valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= head_i.res;
  end

endmodule
